// ===== hdl/xorob_pkg.sv =====
// Shared types and constants for the XOR obfuscation record decryptor.
// Holds the request structs, the function codes and the key padding table.
// No dependencies.
`default_nettype none

package xorob_pkg;

  // Longest password kept; later characters are dropped.
  localparam int unsigned PW_MAX = 15;
  // Length of the key sequence and the modulus of the key offset.
  localparam int unsigned KEY_LEN = 16;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned OFFSET_W = 4;

  // Constant folded into the hash when it is finished.
  localparam logic [15:0] HASH_SEED = 16'hce4b;

  typedef enum logic [1:0] {
    FUNC_PW_CHAR   = 2'd0,
    FUNC_VERIFY    = 2'd1,
    FUNC_REC_START = 2'd2,
    FUNC_DATA      = 2'd3
  } func_t;

  typedef struct packed {
    func_t        func;
    logic [7:0]   byte_value;
    logic [15:0]  filepass_key;
    logic [15:0]  filepass_verifier;
    logic [31:0]  record_position;
    logic [15:0]  record_length;
  } in_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       password_match;
    logic       decrypt_active;
  } out_t;

  typedef logic [7:0] byte_t;

  // Preset bytes that pad a short password to the full key length.
  function automatic byte_t pad_byte(input logic [OFFSET_W-1:0] idx);
    byte_t b;
    case (idx)
      4'd0:    b = 8'hbb;
      4'd1:    b = 8'hff;
      4'd2:    b = 8'hff;
      4'd3:    b = 8'hba;
      4'd4:    b = 8'hff;
      4'd5:    b = 8'hff;
      4'd6:    b = 8'hb9;
      4'd7:    b = 8'h80;
      4'd8:    b = 8'h00;
      4'd9:    b = 8'hbe;
      4'd10:   b = 8'h0f;
      4'd11:   b = 8'h00;
      4'd12:   b = 8'hbf;
      4'd13:   b = 8'h0f;
      4'd14:   b = 8'h00;
      4'd15:   b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/xorob_key_gen.sv =====
// Key sequence builder: pads the stored password, mixes in the key bytes
// and rotates each byte. Depends on xorob_pkg.
`default_nettype none

module xorob_key_gen (
  input  wire xorob_pkg::byte_t                       pw_store [xorob_pkg::PW_MAX],
  input  wire logic [xorob_pkg::COUNT_W-1:0]          pw_count,
  input  wire logic [15:0]                            filepass_key,
  output xorob_pkg::byte_t                            key_seq [xorob_pkg::KEY_LEN]
);

  genvar gi;
  generate
    for (gi = 0; gi < xorob_pkg::KEY_LEN; gi++) begin : g_key
      localparam logic [xorob_pkg::OFFSET_W-1:0] IDX = xorob_pkg::OFFSET_W'(gi);
      xorob_pkg::byte_t src;
      xorob_pkg::byte_t mixed;

      if (gi < xorob_pkg::PW_MAX) begin : g_pw
        // Password character where one was stored, padding after it.
        always_comb begin
          if (IDX < pw_count) begin
            src = pw_store[gi];
          end else begin
            src = xorob_pkg::pad_byte(IDX - pw_count);
          end
        end
      end else begin : g_pad
        always_comb begin
          src = xorob_pkg::pad_byte(IDX - pw_count);
        end
      end

      // Even positions take the low key byte, odd positions the high one.
      assign mixed = src ^ (((gi % 2) != 0) ? filepass_key[15:8] : filepass_key[7:0]);
      assign key_seq[gi] = {mixed[5:0], mixed[7:6]};
    end
  endgenerate

endmodule

`default_nettype wire

// ===== hdl/xor_obfuscation_record_decrypt_top.sv =====
// Top level of the XOR obfuscation record decryptor.
// Depends on xorob_pkg and xorob_key_gen.
`default_nettype none

// Each request carries one function code. A password character is folded
// into a 15-bit rotating hash and stored (up to fifteen nonzero characters;
// zero bytes and characters past the fifteenth are ignored). A verify
// request finishes the hash, compares it with the verifier from the file
// and, on a match, builds the 16-byte key sequence and turns decryption on;
// the password store is cleared on every verify, matched or not. A record
// start request sets the key offset to (position + length + 4) mod 16. A
// data request returns the cipher byte rotated left by three and XORed with
// the key byte at the offset, advancing the offset, or the byte unchanged
// while decryption is off. Every request produces exactly one response.
// Timing: a request is registered at the input, processed by combinational
// logic and placed in the output register, which raises out_valid; while
// the output register is full and stalled it waits in the input register.
// A new request is accepted in every cycle as long as the output side is
// not stalled. The input register and the output register each hold one
// request, so a pending response does not block the next request from
// being registered.
module xor_obfuscation_record_decrypt_top (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire xorob_pkg::in_t    in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output xorob_pkg::out_t        out_data
);

  // Input register.
  logic              s1_valid_r, s1_valid_nxt;
  xorob_pkg::in_t    s1_data_r;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  xorob_pkg::out_t   out_data_r, out_data_nxt;

  // Block state.
  xorob_pkg::byte_t                  pw_store_r [xorob_pkg::PW_MAX];
  logic [xorob_pkg::COUNT_W-1:0]     pw_count_r, pw_count_nxt;
  logic [15:0]                       hash_r, hash_nxt;
  xorob_pkg::byte_t                  key_seq_r [xorob_pkg::KEY_LEN];
  xorob_pkg::byte_t                  key_seq_new [xorob_pkg::KEY_LEN];
  logic [xorob_pkg::OFFSET_W-1:0]    offset_r, offset_nxt;
  logic                              active_r, active_nxt;

  logic              advance;
  logic              fire;
  logic              in_accept;
  logic              store_wr;
  logic              key_wr;
  logic [22:0]       shifted;
  logic [15:0]       final_hash;
  logic [7:0]        rotated;
  logic [xorob_pkg::COUNT_W-1:0] char_num;

  // The processing stage moves forward whenever the output register is
  // empty or its response is being taken in this cycle.
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  xorob_key_gen u_key_gen (
    .pw_store     (pw_store_r),
    .pw_count     (pw_count_r),
    .filepass_key (s1_data_r.filepass_key),
    .key_seq      (key_seq_new)
  );

  // Character number n (from one) is shifted left by n and the bits above
  // the fifteenth wrap around to the bottom.
  assign char_num   = pw_count_r + 4'd1;
  assign shifted    = {15'd0, s1_data_r.byte_value} << char_num;
  assign final_hash = hash_r ^ {12'd0, pw_count_r} ^ xorob_pkg::HASH_SEED;
  assign rotated    = {s1_data_r.byte_value[4:0], s1_data_r.byte_value[7:5]};

  always_comb begin
    pw_count_nxt = pw_count_r;
    hash_nxt     = hash_r;
    offset_nxt   = offset_r;
    active_nxt   = active_r;
    store_wr     = 1'b0;
    key_wr       = 1'b0;
    out_data_nxt = '0;

    case (s1_data_r.func)
      xorob_pkg::FUNC_PW_CHAR: begin
        if (s1_data_r.byte_value != 8'd0 &&
            pw_count_r < xorob_pkg::COUNT_W'(xorob_pkg::PW_MAX)) begin
          hash_nxt     = hash_r ^ {1'b0, shifted[14:0] | {7'd0, shifted[22:15]}};
          pw_count_nxt = char_num;
          store_wr     = 1'b1;
        end
      end
      xorob_pkg::FUNC_VERIFY: begin
        if (final_hash == s1_data_r.filepass_verifier) begin
          out_data_nxt.password_match = 1'b1;
          key_wr     = 1'b1;
          active_nxt = 1'b1;
        end
        // Every verify attempt starts the next password from scratch.
        pw_count_nxt = '0;
        hash_nxt     = '0;
      end
      xorob_pkg::FUNC_REC_START: begin
        // Only the low four bits of the sum survive the mod 16.
        offset_nxt = s1_data_r.record_position[3:0] + s1_data_r.record_length[3:0] +
                     4'd4;
      end
      xorob_pkg::FUNC_DATA: begin
        if (active_r) begin
          out_data_nxt.plain_byte = rotated ^ key_seq_r[offset_r];
          offset_nxt = offset_r + 4'd1;
        end else begin
          out_data_nxt.plain_byte = s1_data_r.byte_value;
        end
      end
      default: begin
        out_data_nxt.plain_byte = 8'd0;
      end
    endcase

    out_data_nxt.decrypt_active = active_nxt;
  end

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pw_count_r  <= '0;
      hash_r      <= '0;
      offset_r    <= '0;
      active_r    <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        pw_count_r <= pw_count_nxt;
        hash_r     <= hash_nxt;
        offset_r   <= offset_nxt;
        active_r   <= active_nxt;
      end
    end
  end

  // Payload registers. Password bytes are only read below the fill count,
  // and key bytes only once a verify has matched and written all of them,
  // so neither needs a reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
    if (fire && store_wr) begin
      pw_store_r[pw_count_r] <= s1_data_r.byte_value;
    end
    if (fire && key_wr) begin
      key_seq_r <= key_seq_new;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for xor_obfuscation_record_decrypt_top.
// Depends on xorob_pkg and on the decryptor RTL. It runs a directed table,
// then random password sessions, and predicts every response in place.
`default_nettype none

module tb;

  // Key padding bytes, first byte in the top lane.
  localparam logic [127:0] KEY_PAD = 128'hbbffffbaffffb980_00be0f00bf0f0000;
  localparam int RANDOM_REQUESTS = 850;

  // One row of the directed table. When golden_given is set, the response
  // is checked against the typed-in value instead of the prediction.
  // When own_verifier is set, the verifier is replaced at send time by the
  // hash of the password entered so far, so that the verify matches.
  typedef struct {
    xorob_pkg::in_t  req;
    bit              own_verifier;
    bit              golden_given;
    xorob_pkg::out_t golden;
  } plan_row_t;

  logic            clk;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  xorob_pkg::in_t  in_data   = '0;
  logic            out_stall = 1'b0;
  logic            in_stall;
  logic            out_valid;
  xorob_pkg::out_t out_data;

  // Shared stimulus state. idle_pct drives the random gaps on both sides.
  int idle_pct   = 35;
  int sent_count = 0;
  bit failed     = 1'b0;

  // Responses still owed by the block, oldest first.
  xorob_pkg::out_t expected_resp[$];

  // Shadow state of the decryptor.
  xorob_pkg::byte_t pw_chars[xorob_pkg::PW_MAX];
  logic [3:0]       pw_len;
  logic [15:0]      pw_hash;
  xorob_pkg::byte_t key_bytes[xorob_pkg::KEY_LEN];
  logic [3:0]       key_ptr;
  bit               unlocked;

  xor_obfuscation_record_decrypt_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #2000000;
    $display("xor_obfuscation_record_decrypt_top verification failed");
    $finish;
  end

  // Finished password hash as a verify request would see it now.
  function automatic logic [15:0] finished_hash();
    return pw_hash ^ {12'd0, pw_len} ^ xorob_pkg::HASH_SEED;
  endfunction

  // Advances the shadow state by one request and returns its response.
  function automatic xorob_pkg::out_t decrypt_step(xorob_pkg::in_t req);
    xorob_pkg::out_t  resp;
    logic [22:0]      shifted;
    xorob_pkg::byte_t b;
    resp = '0;
    case (req.func)
      xorob_pkg::FUNC_PW_CHAR: begin
        // Zero bytes and characters past the fifteenth leave no trace.
        if (req.byte_value != 8'd0 && pw_len < xorob_pkg::PW_MAX) begin
          shifted = {15'd0, req.byte_value} << (pw_len + 4'd1);
          pw_hash ^= {1'b0, shifted[14:0]} | {8'd0, shifted[22:15]};
          pw_chars[pw_len] = req.byte_value;
          pw_len++;
        end
      end
      xorob_pkg::FUNC_VERIFY: begin
        if (finished_hash() == req.filepass_verifier) begin
          resp.password_match = 1'b1;
          for (int i = 0; i < xorob_pkg::KEY_LEN; i++) begin
            b = (i < pw_len) ? pw_chars[i] : KEY_PAD[127 - 8 * (i - pw_len) -: 8];
            b ^= i[0] ? req.filepass_key[15:8] : req.filepass_key[7:0];
            key_bytes[i] = {b[5:0], b[7:6]};
          end
          unlocked = 1'b1;
        end
        // Every attempt, matched or not, starts the next one from scratch.
        foreach (pw_chars[i]) pw_chars[i] = 8'd0;
        pw_len  = '0;
        pw_hash = '0;
      end
      xorob_pkg::FUNC_REC_START: begin
        key_ptr = req.record_position[3:0] + req.record_length[3:0] + 4'd4;
      end
      default: begin
        if (unlocked) begin
          b = {req.byte_value[4:0], req.byte_value[7:5]};
          resp.plain_byte = b ^ key_bytes[key_ptr];
          key_ptr++;
        end else begin
          resp.plain_byte = req.byte_value;
        end
      end
    endcase
    resp.decrypt_active = unlocked;
    return resp;
  endfunction

  // Request with every field random; callers override what they need.
  function automatic xorob_pkg::in_t noise_item();
    xorob_pkg::in_t r;
    r.func              = xorob_pkg::func_t'($urandom_range(3));
    r.byte_value        = 8'($urandom_range(255));
    r.filepass_key      = 16'($urandom_range(65535));
    r.filepass_verifier = 16'($urandom_range(65535));
    r.record_position   = $urandom;
    r.record_length     = 16'($urandom_range(65535));
    return r;
  endfunction

  function automatic plan_row_t row(xorob_pkg::func_t f, xorob_pkg::byte_t bv,
                                    logic [15:0] k, logic [15:0] v,
                                    logic [31:0] p, logic [15:0] l, bit own, bit given,
                                    xorob_pkg::out_t g);
    plan_row_t r;
    r.req = '{f, bv, k, v, p, l};
    r.own_verifier = own;
    r.golden_given = given;
    r.golden = g;
    return r;
  endfunction

  // Offers one request, starting and ending at a falling edge. Random idle
  // cycles come first, with junk on the payload while valid is low. The
  // request is predicted at the rising edge where it is taken.
  task automatic send_request(input xorob_pkg::in_t req, input bit own_verifier,
                              input bit golden_given, input xorob_pkg::out_t golden);
    if (own_verifier) req.filepass_verifier = finished_hash();
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= noise_item();
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    if (golden_given) begin
      void'(decrypt_step(req));
      expected_resp.push_back(golden);
    end else begin
      expected_resp.push_back(decrypt_step(req));
    end
    sent_count++;
    @(negedge clk);
  endtask

  // Response side. Once enough requests have gone in, it holds the output
  // off for a long stretch so that both registers fill and in_stall rises.
  initial begin
    int  hold_left;
    bit  squeeze_done;
    hold_left    = 0;
    squeeze_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!squeeze_done && sent_count >= 150) begin
        squeeze_done = 1'b1;
        hold_left    = 80;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
      end
    end
  end

  // Each response taken is compared with the oldest expectation.
  always @(posedge clk) begin : check_resp
    xorob_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_resp.size() == 0) begin
        $error("response %h arrived with nothing expected", out_data);
        failed = 1'b1;
      end else begin
        want = expected_resp.pop_front();
        if (out_data.plain_byte !== want.plain_byte) begin
          $error("plain_byte: expected %02h, got %02h",
                 want.plain_byte, out_data.plain_byte);
          failed = 1'b1;
        end
        if (out_data.password_match !== want.password_match) begin
          $error("password_match: expected %b, got %b",
                 want.password_match, out_data.password_match);
          failed = 1'b1;
        end
        if (out_data.decrypt_active !== want.decrypt_active) begin
          $error("decrypt_active: expected %b, got %b",
                 want.decrypt_active, out_data.decrypt_active);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    plan_row_t      plan[$];
    xorob_pkg::in_t req;
    int             n_chars;
    int             n_bytes;
    int             n_directed;
    bit             own;

    foreach (pw_chars[i]) pw_chars[i] = 8'd0;
    foreach (key_bytes[i]) key_bytes[i] = 8'd0;
    pw_len   = '0;
    pw_hash  = '0;
    key_ptr  = '0;
    unlocked = 1'b0;

    // Directed table. Out of reset decryption is off, so data passes as is
    // and a record start only moves the offset (0 + 0 + 4 here).
    plan.push_back(row(xorob_pkg::FUNC_DATA, 8'ha5, 16'h0, 16'h0, 32'h0, 16'h0, 0, 1,
                       '{8'ha5, 1'b0, 1'b0}));
    plan.push_back(row(xorob_pkg::FUNC_REC_START, 8'h00, 16'h0, 16'h0, 32'h0, 16'h0, 0, 1,
                       '{8'h00, 1'b0, 1'b0}));
    plan.push_back(row(xorob_pkg::FUNC_DATA, 8'h3c, 16'h0, 16'h0, 32'h0, 16'h0, 0, 1,
                       '{8'h3c, 1'b0, 1'b0}));
    // An empty password hashes to the seed alone, so this verify matches.
    plan.push_back(row(xorob_pkg::FUNC_VERIFY, 8'h00, 16'hffff, 16'hce4b, 32'h0, 16'h0,
                       0, 1, '{8'h00, 1'b1, 1'b1}));
    // A failed verify leaves decryption on with the old key sequence.
    plan.push_back(row(xorob_pkg::FUNC_VERIFY, 8'hff, 16'h1234, 16'h0000, 32'h0, 16'h0,
                       0, 1, '{8'h00, 1'b0, 1'b1}));
    // Largest position and length wrap the offset around to 2.
    plan.push_back(row(xorob_pkg::FUNC_REC_START, 8'h00, 16'h0, 16'h0, 32'hffffffff,
                       16'hffff, 0, 1, '{8'h00, 1'b0, 1'b1}));
    plan.push_back(row(xorob_pkg::FUNC_DATA, 8'h00, 16'h0, 16'h0, 32'h0, 16'h0, 0, 0, '0));
    plan.push_back(row(xorob_pkg::FUNC_DATA, 8'hff, 16'h0, 16'h0, 32'h0, 16'h0, 0, 0, '0));
    // A zero character is dropped like a terminator.
    plan.push_back(row(xorob_pkg::FUNC_PW_CHAR, 8'h00, 16'h0, 16'h0, 32'h0, 16'h0, 0, 1,
                       '{8'h00, 1'b0, 1'b1}));
    // Sixteen characters: the last one falls beyond the store and is ignored.
    for (int i = 0; i < 16; i++) begin
      plan.push_back(row(xorob_pkg::FUNC_PW_CHAR,
                         (i == 0) ? 8'hff : (i == 1) ? 8'h01 : 8'(8'h40 + i),
                         16'h0, 16'h0, 32'h0, 16'h0, 0, 1, '{8'h00, 1'b0, 1'b1}));
    end
    // A second match rebuilds the key from the full password.
    plan.push_back(row(xorob_pkg::FUNC_VERIFY, 8'h00, 16'h0000, 16'h0, 32'h0, 16'h0, 1, 1,
                       '{8'h00, 1'b1, 1'b1}));
    plan.push_back(row(xorob_pkg::FUNC_REC_START, 8'h00, 16'h0, 16'h0, 32'h0000000c, 16'h0,
                       0, 0, '0));
    plan.push_back(row(xorob_pkg::FUNC_DATA, 8'h5a, 16'h0, 16'h0, 32'h0, 16'h0, 0, 0, '0));
    plan.push_back(row(xorob_pkg::FUNC_DATA, 8'h81, 16'h0, 16'h0, 32'h0, 16'h0, 0, 0, '0));
    n_directed = plan.size();

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      send_request(plan[i].req, plan[i].own_verifier, plan[i].golden_given, plan[i].golden);
    end

    // Random part. Most of it is whole sessions: a password, a verify that
    // usually matches, a record start and a run of data bytes. The rest is
    // single random requests. A verify meant to miss has one bit flipped or a random verifier.
    while (sent_count < n_directed + RANDOM_REQUESTS) begin
      // A stretch in the middle runs with neither side idling.
      idle_pct = (sent_count >= 400 && sent_count < 550) ? 0 : 35;
      if ($urandom_range(99) < 80) begin
        n_chars = $urandom_range(17);
        repeat (n_chars) begin
          req = noise_item();
          req.func = xorob_pkg::FUNC_PW_CHAR;
          if ($urandom_range(9) == 0) req.byte_value = 8'd0;
          send_request(req, 0, 0, '0);
        end
        req = noise_item();
        req.func = xorob_pkg::FUNC_VERIFY;
        own = ($urandom_range(99) < 75);
        if (!own && $urandom_range(1) == 1)
          req.filepass_verifier = finished_hash() ^ (16'h1 << $urandom_range(15));
        send_request(req, own, 0, '0);
        req = noise_item();
        req.func = xorob_pkg::FUNC_REC_START;
        send_request(req, 0, 0, '0);
        n_bytes = $urandom_range(1, 24);
        repeat (n_bytes) begin
          req = noise_item();
          req.func = xorob_pkg::FUNC_DATA;
          send_request(req, 0, 0, '0);
        end
      end else begin
        send_request(noise_item(), 0, 0, '0);
      end
    end
    in_valid <= 1'b0;

    // Drain, then keep watching for any stray response before the verdict.
    while (expected_resp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (!failed) begin
      $display("xor_obfuscation_record_decrypt_top verification clean");
    end else begin
      $display("xor_obfuscation_record_decrypt_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/xorob_pkg.sv
hdl/xorob_key_gen.sv
hdl/xor_obfuscation_record_decrypt_top.sv
verif/tb.sv
